// ===== rtl/lrt_pkg.sv =====
// shared types and constants for the lru recency tracker
`timescale 1ns / 1ps
package lrt_pkg;

  localparam int ACT_W = 3;
  localparam int ID_W  = 31;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ID_W-1:0]  page_id_t;

  localparam action_t ACT_ACCESS = 3'd0;
  localparam action_t ACT_ADD    = 3'd1;
  localparam action_t ACT_REMOVE = 3'd2;
  localparam action_t ACT_CLEAR  = 3'd3;
  localparam action_t ACT_QUERY  = 3'd4;

  // list-wide operation broadcast to every cell
  typedef struct packed {
    logic mtf;  // move the matching page to the front
    logic ins;  // insert a new page at the front
    logic del;  // delete the matching page
  } lrt_op_t;

endpackage

// ===== rtl/lrt_cell.sv =====
// one position of the recency list: stored id, match and neighbor shift
`timescale 1ns / 1ps
module lrt_cell
  import lrt_pkg::*;
(
  input  logic     clk,
  input  lrt_op_t  op,
  input  logic     valid,
  input  page_id_t page_id,
  input  logic     seen_in,
  output logic     seen_out,
  input  page_id_t left_id,
  input  page_id_t right_id,
  output page_id_t id
);

  page_id_t id_r;
  page_id_t id_nxt;
  logic     match;
  logic     take_left;
  logic     take_right;

  assign match      = valid && (id_r == page_id);
  assign seen_out   = seen_in | match;
  assign take_left  = op.ins | (op.mtf & ~seen_in);
  assign take_right = op.del & seen_out;
  assign id         = id_r;

  always_comb begin
    id_nxt = id_r;
    if (take_left) begin
      id_nxt = left_id;
    end else if (take_right) begin
      id_nxt = right_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// ===== rtl/lru_recency_tracker.sv =====
// top level of the lru recency tracker: chain of list cells and result register
`timescale 1ns / 1ps
//  channel   ports                                         transfer
//  input     start, busy, in_action, in_page_id            start & ~busy
//  result    out_valid, out_hit, out_lru_valid,            out_valid
//            out_lru_page, out_count, out_refused
//
//  one item per cycle; busy stays low, the list updates at the accepting edge
//  the result strobes after acceptance through pend_r and pend2_r, read from the updated cells
//  all cells compare the page id in parallel; the match prefix ripples
//  along the chain and sets each cell's shift direction
//  synchronous reset empties the list; ids are not cleared
//  the receiver cannot stall, so results are never held back
module lru_recency_tracker
  import lrt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ACT_W-1:0]                 in_action,
  input  logic [ID_W-1:0]                  in_page_id,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_lru_valid,
  output logic [ID_W-1:0]                  out_lru_page,
  output logic [$clog2(ENTRIES+1)-1:0]     out_count,
  output logic                             out_refused
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic                 accept;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 pend_r, pend2_r;
  logic                 hit_d_r, ref_d_r;
  logic                 hit;
  logic                 full;
  logic                 refused;
  lrt_op_t              op;
  logic [ENTRIES:0]     seen;
  page_id_t             ids [ENTRIES];
  page_id_t             lru_sel;

  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign full     = (count_r == CNT_W'(ENTRIES));
  assign seen[0]  = 1'b0;
  assign hit      = seen[ENTRIES];

  always_comb begin
    op      = '0;
    refused = 1'b0;
    if (accept) begin
      unique case (in_action)
        ACT_ACCESS: begin
          op.mtf = hit;
        end
        ACT_ADD: begin
          op.mtf  = hit;
          op.ins  = ~hit & ~full;
          refused = ~hit & full;
        end
        ACT_REMOVE: begin
          op.del = hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept && in_action == ACT_CLEAR) begin
      count_nxt = '0;
    end else if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    page_id_t left_id;
    page_id_t right_id;
    if (i == 0) begin : g_first
      assign left_id = in_page_id;
    end else begin : g_mid
      assign left_id = ids[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = ids[i+1];
    end
    lrt_cell u_cell (
      .clk      (clk),
      .op       (op),
      .valid    (CNT_W'(i) < count_r),
      .page_id  (in_page_id),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .left_id  (left_id),
      .right_id (right_id),
      .id       (ids[i])
    );
  end

  // and-or select of the cell at the tail of the list
  always_comb begin
    lru_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        lru_sel = lru_sel | ids[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      pend2_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= accept;
      pend2_r <= pend_r;
    end
  end

  logic hit_d2_r, ref_d2_r;

  always_ff @(posedge clk) begin
    hit_d_r       <= hit;
    ref_d_r       <= refused;
    hit_d2_r      <= hit_d_r;
    ref_d2_r      <= ref_d_r;
    out_lru_valid <= (count_r != '0);
    out_lru_page  <= lru_sel;
    out_count     <= count_r;
  end

  assign out_valid   = pend2_r;
  assign out_hit     = hit_d2_r;
  assign out_refused = ref_d2_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("occupancy above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_CLEAR |=> count_r == '0)
    else $error("clear left entries");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    refused |-> full && !hit)
    else $error("refused without a full list");

  a_lru_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lru_valid == (out_count != '0))
    else $error("lru valid disagrees with count");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("occupancy changed without a transfer");

endmodule
